/* sv/lzss_wtd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_wtd_pkg
// Shared types, constants and helpers of the LZSS window token decoder.
// ----------------------------------------------------------------------------
package lzss_wtd_pkg;

	// window and match limits
	localparam int MAX_WINDOW_BITS   = 17;
	localparam int LOW_WINDOW_BITS   = 12;
	localparam int RESET_WINDOW_BITS = 17;
	localparam int MAX_MATCH_LEN     = 64;
	localparam int MIN_MATCH_LEN     = 4;

	// field and storage widths
	localparam int POS_W     = MAX_WINDOW_BITS;
	localparam int FILL_W    = MAX_WINDOW_BITS + 1;
	localparam int LEN_W     = 7;
	localparam int WBITS_W   = 5;
	localparam int IDX_W     = $clog2(MAX_MATCH_LEN);
	localparam int WIN_DEPTH = 1 << MAX_WINDOW_BITS;

	// register port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_WINDOW_BITS = 1'b0;

	// token kinds
	localparam logic CMD_LITERAL = 1'b0;
	localparam logic CMD_MATCH   = 1'b1;

	typedef struct packed {
		logic             command;
		logic [7:0]       literal_byte;
		logic [POS_W-1:0] match_position;
		logic [LEN_W-1:0] match_length;
	} token_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} stream_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE
	} state_t;

	// position wrap mask for a window_bits setting, clamped to the legal range
	function automatic logic [POS_W-1:0] pos_wrap_mask(input logic [WBITS_W-1:0] wbits);
		logic [WBITS_W-1:0] eff;
		eff = wbits;
		if (eff < WBITS_W'(LOW_WINDOW_BITS)) begin
			eff = WBITS_W'(LOW_WINDOW_BITS);
		end
		if (eff > WBITS_W'(MAX_WINDOW_BITS)) begin
			eff = WBITS_W'(MAX_WINDOW_BITS);
		end
		return {POS_W{1'b1}} >> (WBITS_W'(MAX_WINDOW_BITS) - eff);
	endfunction

	// index of the final byte of a match, length saturated to the legal range
	function automatic logic [IDX_W-1:0] last_index(input logic [LEN_W-1:0] len);
		logic [IDX_W-1:0] res;
		if (len < LEN_W'(MIN_MATCH_LEN)) begin
			res = IDX_W'(MIN_MATCH_LEN - 1);
		end else if (len > LEN_W'(MAX_MATCH_LEN)) begin
			res = IDX_W'(MAX_MATCH_LEN - 1);
		end else begin
			res = IDX_W'(len - LEN_W'(1));
		end
		return res;
	endfunction

endpackage

/* sv/lzss_window_token_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_window_token_decoder
// Rebuilds the byte stream from parsed LZSS tokens using a sliding window
// memory and a match staging memory.
// ----------------------------------------------------------------------------
//  port group   dir  handshake              content
//  token        in   token_valid/ready      command, literal, position, length
//  stream       out  stream_valid/ready     out_byte, last
//  apb          in   psel/penable/pready    window_bits register at 0x0
//
//  a literal leaves one byte in the output buffer; a match of n bytes is
//  n window reads into staging (n clamped to 4..64), then n staging reads
//  written back to the window and emitted, one per cycle unless stalled
//  the read-all-then-write order is kept because reads and writes of a match
//  cannot overlap, since the copy must see the window as it stood before it
//  a 2-entry output buffer holds finished bytes; a stalled stream pauses the
//  write-back phase and, once the buffer is full, token intake
//  after reset the window reads as zero through a fill count; no clear pass
// ----------------------------------------------------------------------------
module lzss_window_token_decoder
	import lzss_wtd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// token request channel
	input  logic                  token_valid,
	output logic                  token_ready,
	input  token_t                token,
	// byte stream channel
	output logic                  stream_valid,
	input  logic                  stream_ready,
	output stream_t               stream,
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// control state
	state_t             state_q, state_d;
	logic [WBITS_W-1:0] wbits_q;
	logic [POS_W-1:0]   wp_q;
	logic [FILL_W-1:0]  fill_q;
	logic [POS_W-1:0]   pos_q;
	logic [IDX_W-1:0]   last_idx_q;
	logic [IDX_W-1:0]   idx_q;

	// read-phase pipeline
	logic               rd_v_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               rd_zero_s1;
	logic [7:0]         win_rdata_s1;

	// write-back pipeline
	logic               st_v_s1;
	logic               st_last_s1;
	logic [7:0]         stg_rdata_s1;

	// output buffer
	stream_t            fifo_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         occ_q;

	// memories
	logic [7:0]         win_mem [WIN_DEPTH];
	logic [7:0]         stg_mem [MAX_MATCH_LEN];

	// combinational controls
	logic [POS_W-1:0]   mask;
	logic [POS_W-1:0]   wp_eff;
	logic [POS_W-1:0]   rd_addr;
	logic               rd_zero;
	logic               tok_acc;
	logic               pop;
	logic               space;
	logic               rd_issue;
	logic               st_issue;
	logic               lit_wr;
	logic               win_we;
	logic [7:0]         win_wdata;
	logic               push;
	stream_t            push_data;
	logic               cfg_wr;

	// address and handshake terms
	assign mask     = pos_wrap_mask(wbits_q);
	assign wp_eff   = wp_q & mask;
	assign rd_addr  = (pos_q + POS_W'(idx_q)) & mask;
	assign rd_zero  = {1'b0, rd_addr} >= fill_q;
	assign tok_acc  = token_valid && token_ready;
	assign pop      = stream_valid && stream_ready;
	assign space    = ({1'b0, occ_q} + 3'(st_v_s1)) < (3'd2 + 3'(pop));
	assign lit_wr   = tok_acc && (token.command == CMD_LITERAL);
	assign win_we   = lit_wr || st_v_s1;
	assign win_wdata = lit_wr ? token.literal_byte : stg_rdata_s1;
	assign push     = win_we;
	assign push_data = lit_wr ? stream_t'{out_byte: token.literal_byte, last: 1'b1}
	                          : stream_t'{out_byte: stg_rdata_s1, last: st_last_s1};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tok_acc && token.command == CMD_MATCH) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (idx_q == last_idx_q) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (st_issue && idx_q == last_idx_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		token_ready = 1'b0;
		rd_issue    = 1'b0;
		st_issue    = 1'b0;
		unique case (state_q)
			ST_IDLE:  token_ready = !st_v_s1 && (occ_q < 2'd2 || pop);
			ST_READ:  rd_issue = 1'b1;
			ST_WRITE: st_issue = space;
			default: begin
				token_ready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wp_q       <= '0;
			fill_q     <= '0;
			idx_q      <= '0;
			rd_v_s1    <= 1'b0;
			st_v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_issue;
			st_v_s1 <= st_issue;
			if (tok_acc && token.command == CMD_MATCH) begin
				wp_q  <= wp_eff;
				idx_q <= '0;
			end else if (win_we) begin
				wp_q <= (wp_eff + POS_W'(1)) & mask;
			end
			if (win_we && {1'b0, wp_eff} == fill_q) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (rd_issue) begin
				idx_q <= (idx_q == last_idx_q) ? '0 : idx_q + IDX_W'(1);
			end else if (st_issue) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// match parameters and pipeline payload
	always_ff @(posedge clk) begin
		if (tok_acc && token.command == CMD_MATCH) begin
			pos_q      <= token.match_position & mask;
			last_idx_q <= last_index(token.match_length);
		end
		rd_idx_s1  <= idx_q;
		rd_zero_s1 <= rd_zero;
		st_last_s1 <= (idx_q == last_idx_q);
	end

	// window memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[wp_eff] <= win_wdata;
		end
		win_rdata_s1 <= win_mem[rd_addr];
	end

	// staging memory, unwritten window bytes read as zero
	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			stg_mem[rd_idx_s1] <= rd_zero_s1 ? 8'h00 : win_rdata_s1;
		end
		stg_rdata_s1 <= stg_mem[idx_q];
	end

	// output buffer pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			occ_q <= occ_q + 2'(push) - 2'(pop);
		end
	end

	// output buffer data
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	assign stream_valid = (occ_q != 2'd0);
	assign stream       = fifo_q[rd_ptr_q];

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wbits_q <= WBITS_W'(RESET_WINDOW_BITS);
		end else if (cfg_wr && paddr[APB_ADDR_W-1] == REG_WINDOW_BITS) begin
			wbits_q <= pwdata[WBITS_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[APB_ADDR_W-1] == REG_WINDOW_BITS) begin
			prdata = APB_DATA_W'(wbits_q);
		end
	end

	// no push into a full output buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (occ_q < 2'd2 || pop))
		else $error("output buffer overflow");

	// a new token never meets a write-back still in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		token_ready |-> (!st_v_s1 && !rd_v_s1))
		else $error("token taken during write-back");

	// window writes stay inside the filled prefix or extend it by one
	assert property (@(posedge clk) disable iff (!arst_n)
		win_we |-> ({1'b0, wp_eff} <= fill_q))
		else $error("window write beyond fill count");

	// window reads and writes of a match never overlap
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> !win_we)
		else $error("window read during write");

endmodule
